[rtl/core/dtsh_pkg.sv]
// Package for the hashed-set directory tag store: sizes, codes, shared types.
// No dependencies.
package dtsh_pkg;

  localparam int NumSets     = 1024;
  localparam int Ways        = 16;
  localparam int VictimSlots = 16;
  localparam int AddrBits    = 48;
  localparam int SetBits     = $clog2(NumSets);
  localparam int WayBits     = $clog2(Ways);
  localparam int SlotBits    = $clog2(VictimSlots);
  localparam int QDepth      = 2;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [SetBits-1:0]  set_t;
  typedef logic [WayBits-1:0]  way_t;
  typedef logic [SlotBits-1:0] slot_t;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_CAND   = 2'd1,
    FN_REPL   = 2'd2,
    FN_INVAL  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_ALLOC = 3'd1,
    ST_VHIT  = 3'd2,
    ST_MISS  = 3'd3,
    ST_REPL  = 3'd4,
    ST_INVAL = 3'd5,
    ST_CAND  = 3'd6,
    ST_ERR   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOG_BLOCK = 2'd0,
    CFG_LOG_MC    = 2'd1,
    CFG_LOG_STACK = 2'd2,
    CFG_LOG_CORES = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_EVAL,
    BK_LIST,
    BK_OUT
  } back_e;

  // Request as classified by the front part.
  typedef struct packed {
    func_e func;
    addr_t addr;
    addr_t new_addr;
    set_t  set;
  } req_t;

  typedef struct packed {
    status_e status;
    set_t    set;
    way_t    way;
    slot_t   slot;
    addr_t   addr;
    logic    last;
  } rsp_t;

endpackage

[rtl/core/dtsh_front.sv]
// Front part: takes requests, hashes the set index, queues classified requests.
// Depends on dtsh_pkg.
module dtsh_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  dtsh_pkg::addr_t      address_i,
  input  dtsh_pkg::addr_t      new_address_i,
  input  logic [3:0]           log_block_size_i,
  input  logic [2:0]           log_mem_controllers_i,
  input  logic [5:0]           log_stack_size_i,
  input  logic [3:0]           log_core_count_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output dtsh_pkg::req_t       q_req_o
);
  import dtsh_pkg::*;

  localparam int CntBits = $clog2(QDepth + 1);
  localparam int PtrBits = $clog2(QDepth);

  req_t                q_mem [QDepth];
  logic [PtrBits-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                push, pop;
  logic [4:0]          lc, sub_bits;
  logic [4:0]          base;
  set_t                cmask, smask, core, sub, sup;
  req_t                req;

  always_comb begin
    lc       = (log_core_count_i > 4'(SetBits)) ? 5'(SetBits) : 5'(log_core_count_i);
    sub_bits = 5'(SetBits) - lc;
    base     = 5'(log_block_size_i) + 5'(log_mem_controllers_i);
    cmask    = set_t'((1 << lc) - 1);
    smask    = set_t'((1 << sub_bits) - 1);
    core     = set_t'(address_i >> log_stack_size_i) & cmask;
    sub      = set_t'(address_i >> base) & smask;
    sup      = set_t'(address_i >> (6'(base) + 6'(sub_bits))) & cmask;
    req.func     = func_e'(func_i);
    req.addr     = address_i;
    req.new_addr = new_address_i;
    req.set      = ((core ^ sup) << sub_bits) | sub;
  end

  assign in_ready_o = (cnt_q != CntBits'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_req_o    = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrBits'((32'(wr_ptr_q) + 1) % QDepth) : wr_ptr_q;
    rd_ptr_d = pop ? PtrBits'((32'(rd_ptr_q) + 1) % QDepth) : rd_ptr_q;
    cnt_d    = cnt_q + CntBits'(push) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= req;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(QDepth)) else $error("queue count overflow");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntBits'(QDepth)) |-> !push) else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not tracking");

endmodule

[rtl/core/dtsh_back.sv]
// Back part: reads the set row, compares ways, updates stores, emits results.
// Depends on dtsh_pkg.
module dtsh_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  dtsh_pkg::req_t q_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dtsh_pkg::rsp_t out_rsp_o
);
  import dtsh_pkg::*;

  // Tag memory: one row per set, all ways side by side.
  addr_t               tag_mem [NumSets][Ways];
  addr_t               row_q [Ways];
  logic [Ways-1:0]     vld_mem [NumSets];
  logic [Ways-1:0]     row_vld_q;
  addr_t               vic_addr_q [VictimSlots];
  logic [VictimSlots-1:0] vic_vld_q, vic_vld_d;

  back_e   state_q, state_d;
  req_t    req_q;
  rsp_t    rsp_q, rsp_d;
  way_t    cnt_q, cnt_d;
  set_t    clr_q, clr_d;
  logic    take;

  logic [Ways-1:0]        hit_vec;
  logic [VictimSlots-1:0] vhit_vec;
  logic                   any_hit, any_free, any_vhit, any_vfree;
  way_t                   hit_way, free_way;
  slot_t                  vhit_slot, vfree_slot;
  logic                   wr_en, vld_set;
  way_t                   wr_way;
  addr_t                  wr_addr;
  logic                   vic_wr;
  slot_t                  vic_slot;
  logic                   vld_we;
  set_t                   vld_waddr;
  logic [Ways-1:0]        vld_wdata;

  always_comb begin
    hit_vec  = '0;
    vhit_vec = '0;
    for (int i = 0; i < Ways; i++) begin
      hit_vec[i] = row_vld_q[i] && (row_q[i] == req_q.addr);
    end
    for (int s = 0; s < VictimSlots; s++) begin
      vhit_vec[s] = vic_vld_q[s] && (vic_addr_q[s] == req_q.addr);
    end
  end

  always_comb begin
    any_hit = 1'b0; hit_way = '0;
    any_free = 1'b0; free_way = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin any_hit = 1'b1; hit_way = way_t'(i); end
      if (!row_vld_q[i]) begin any_free = 1'b1; free_way = way_t'(i); end
    end
    any_vhit = 1'b0; vhit_slot = '0;
    any_vfree = 1'b0; vfree_slot = '0;
    for (int s = VictimSlots - 1; s >= 0; s--) begin
      if (vhit_vec[s]) begin any_vhit = 1'b1; vhit_slot = slot_t'(s); end
      if (!vic_vld_q[s]) begin any_vfree = 1'b1; vfree_slot = slot_t'(s); end
    end
  end

  assign take = q_valid_i && q_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_q == set_t'(NumSets - 1)) state_d = BK_IDLE;
      BK_IDLE: if (q_valid_i) state_d = BK_READ;
      BK_READ: state_d = (req_q.func == FN_CAND) ? BK_LIST : BK_EVAL;
      BK_EVAL: state_d = BK_OUT;
      BK_LIST: if (out_ready_i && cnt_q == way_t'(Ways - 1)) state_d = BK_IDLE;
      BK_OUT:  if (out_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o   = (state_q == BK_IDLE);
    out_valid_o = (state_q == BK_LIST) || (state_q == BK_OUT);
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    rsp_d       = rsp_q;
    wr_en = 1'b0; vld_set = 1'b0; wr_way = '0; wr_addr = req_q.addr;
    vic_wr = 1'b0; vic_slot = '0;
    vic_vld_d = vic_vld_q;
    if (state_q == BK_CLEAR) clr_d = clr_q + 1'b1;
    if (state_q == BK_READ) cnt_d = '0;
    if (state_q == BK_LIST && out_ready_i) cnt_d = cnt_q + 1'b1;
    if (state_q == BK_EVAL) begin
      rsp_d = '{status: ST_ERR, set: req_q.set, way: '0, slot: '0, addr: '0, last: 1'b1};
      case (req_q.func)
        FN_LOOKUP: begin
          if (any_hit) begin
            rsp_d.status = ST_HIT; rsp_d.way = hit_way; rsp_d.addr = req_q.addr;
          end else if (any_free) begin
            rsp_d.status = ST_ALLOC; rsp_d.way = free_way; rsp_d.addr = req_q.addr;
            wr_en = 1'b1; vld_set = 1'b1; wr_way = free_way;
          end else if (any_vhit) begin
            rsp_d.status = ST_VHIT; rsp_d.slot = vhit_slot; rsp_d.addr = req_q.addr;
          end else begin
            rsp_d.status = ST_MISS;
          end
        end
        FN_REPL: begin
          if (any_hit && any_vfree) begin
            rsp_d.status = ST_REPL; rsp_d.way = hit_way; rsp_d.slot = vfree_slot;
            rsp_d.addr = req_q.new_addr;
            wr_en = 1'b1; wr_way = hit_way; wr_addr = req_q.new_addr;
            vic_wr = 1'b1; vic_slot = vfree_slot;
            vic_vld_d[vfree_slot] = 1'b1;
          end
        end
        FN_INVAL: begin
          if (any_vhit) begin
            rsp_d.status = ST_INVAL; rsp_d.slot = vhit_slot; rsp_d.addr = req_q.addr;
            vic_vld_d[vhit_slot] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    // valid rows: swept to zero after reset, then whole-row updates on allocate
    vld_we    = (state_q == BK_CLEAR) || (wr_en && vld_set);
    vld_waddr = (state_q == BK_CLEAR) ? clr_q : req_q.set;
    vld_wdata = (state_q == BK_CLEAR) ? '0
                                      : (row_vld_q | ({{(Ways-1){1'b0}}, 1'b1} << wr_way));
  end

  always_comb begin
    out_rsp_o = rsp_q;
    if (state_q == BK_LIST) begin
      out_rsp_o.status = ST_CAND;
      out_rsp_o.set    = req_q.set;
      out_rsp_o.way    = cnt_q;
      out_rsp_o.slot   = '0;
      out_rsp_o.addr   = row_vld_q[cnt_q] ? row_q[cnt_q] : '0;
      out_rsp_o.last   = (cnt_q == way_t'(Ways - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      cnt_q     <= '0;
      clr_q     <= '0;
      vic_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_q     <= clr_d;
      vic_vld_q <= vic_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) req_q <= q_req_i;
    rsp_q <= rsp_d;
    if (state_q == BK_READ) begin
      row_q     <= tag_mem[req_q.set];
      row_vld_q <= vld_mem[req_q.set];
    end
    if (wr_en) tag_mem[req_q.set][wr_way] <= wr_addr;
    if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
    if (vic_wr) vic_addr_q[vic_slot] <= req_q.addr;
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> state_q == BK_READ) else $error("request not started");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_OUT && !out_ready_i) |=> state_q == BK_OUT) else $error("result dropped");
  a_list_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_LIST && out_ready_i && out_rsp_o.last) |=> state_q == BK_IDLE)
    else $error("listing overrun");

endmodule

[rtl/core/directory_tag_store_hashed_sets_unit.sv]
// Top level of the hashed-set directory tag store: config registers, front, back.
// Depends on dtsh_pkg, dtsh_front, dtsh_back.
//
//  channel | signals                                     | direction
//  in      | in_valid_i/in_ready_o, func/address/new_addr| request in
//  out     | out_valid_o/out_ready_i, status..last       | result out
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index/data     | register write
//
// A lookup, replace or invalidate goes through four states in the back part (take,
// set row read, compare, result); a candidate listing takes, reads the set row and
// then lists the Ways entries, one per accepted result. A two-entry queue lets
// the front accept while the back works or waits on out_ready_i. After reset
// the back sweeps all NumSets (1024) valid rows to zero before taking a request.
module directory_tag_store_hashed_sets_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [47:0]            address_i,
  input  logic [47:0]            new_address_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [9:0]             set_idx_o,
  output logic [3:0]             way_o,
  output logic [3:0]             victim_slot_o,
  output logic [47:0]            entry_address_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import dtsh_pkg::*;

  logic [3:0] log_block_size_q;
  logic [2:0] log_mem_controllers_q;
  logic [5:0] log_stack_size_q;
  logic [3:0] log_core_count_q;
  logic       q_valid, q_ready;
  req_t       q_req;
  rsp_t       rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_block_size_q      <= 4'd6;
      log_mem_controllers_q <= 3'd0;
      log_stack_size_q      <= 6'd24;
      log_core_count_q      <= 4'd4;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_LOG_BLOCK: log_block_size_q      <= cfg_data_i[3:0];
        CFG_LOG_MC:    log_mem_controllers_q <= cfg_data_i[2:0];
        CFG_LOG_STACK: log_stack_size_q      <= cfg_data_i[5:0];
        CFG_LOG_CORES: log_core_count_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  dtsh_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .address_i, .new_address_i,
    .log_block_size_i(log_block_size_q), .log_mem_controllers_i(log_mem_controllers_q),
    .log_stack_size_i(log_stack_size_q), .log_core_count_i(log_core_count_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  dtsh_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .out_rsp_o(rsp)
  );

  assign status_o        = rsp.status;
  assign set_idx_o       = rsp.set;
  assign way_o           = rsp.way;
  assign victim_slot_o   = rsp.slot;
  assign entry_address_o = rsp.addr;
  assign last_o          = rsp.last;

endmodule

[bench/directory_tag_store_hashed_sets_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the hashed-set directory tag store: random and directed requests,
// register phases, an in-bench predictor and an in-order result scoreboard.
// Depends on dtsh_pkg and directory_tag_store_hashed_sets_unit.
module directory_tag_store_hashed_sets_unit_tb;
  import dtsh_pkg::*;

  typedef struct {
    func_e func;
    addr_t addr;
    addr_t new_addr;
  } dir_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = '0;
  logic [47:0] address_i = '0;
  logic [47:0] new_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [9:0]  set_idx_o;
  logic [3:0]  way_o;
  logic [3:0]  victim_slot_o;
  logic [47:0] entry_address_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  directory_tag_store_hashed_sets_unit uut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  addr_t tag_addr [NumSets*Ways];
  logic  tag_vld  [NumSets*Ways];
  addr_t vic_addr [VictimSlots];
  logic  vic_vld  [VictimSlots];
  int    lg_block, lg_mc, lg_stack, lg_cores;

  dir_req_t pending_reqs[$];
  rsp_t     expected_rsps[$];
  addr_t    addr_pool[$];
  int       errors = 0;
  int       cycles = 0;
  logic     idle_off = 1'b0;
  logic     hold_req = 1'b0, hold_done = 1'b0;
  int       hold_cnt = 0;
  int       tx_gap = 0, rx_gap = 0;
  logic     tx_calm = 1'b0, rx_calm = 1'b0;

  function automatic set_t hashed_set(addr_t a);
    int lc, sub_bits, base;
    logic [63:0] a64, cmask, smask, core, sub, sup;
    lc = (lg_cores > SetBits) ? SetBits : lg_cores;
    sub_bits = SetBits - lc;
    base = lg_block + lg_mc;
    a64 = {16'd0, a};
    cmask = (64'd1 << lc) - 1;
    smask = (64'd1 << sub_bits) - 1;
    core = (a64 >> lg_stack) & cmask;
    sub = (a64 >> base) & smask;
    sup = (a64 >> (base + sub_bits)) & cmask;
    return set_t'(((core ^ sup) << sub_bits) | sub);
  endfunction

  function automatic void push_rsp(status_e st, set_t s, int w, int sl, addr_t a, logic l);
    rsp_t r;
    r.status = st; r.set = s; r.way = way_t'(w); r.slot = slot_t'(sl);
    r.addr = a; r.last = l;
    expected_rsps = {expected_rsps, r};
  endfunction

  function automatic void predict_directory(func_e f, addr_t a, addr_t na);
    set_t s;
    int   row;
    s = hashed_set(a);
    row = int'(s) * Ways;
    case (f)
      FN_LOOKUP: begin
        for (int w = 0; w < Ways; w++)
          if (tag_vld[row+w] && tag_addr[row+w] == a) begin
            push_rsp(ST_HIT, s, w, 0, a, 1'b1); return;
          end
        for (int w = 0; w < Ways; w++)
          if (!tag_vld[row+w]) begin
            tag_vld[row+w] = 1'b1; tag_addr[row+w] = a;
            push_rsp(ST_ALLOC, s, w, 0, a, 1'b1); return;
          end
        for (int v = 0; v < VictimSlots; v++)
          if (vic_vld[v] && vic_addr[v] == a) begin
            push_rsp(ST_VHIT, s, 0, v, a, 1'b1); return;
          end
        push_rsp(ST_MISS, s, 0, 0, '0, 1'b1);
      end
      FN_CAND: begin
        for (int w = 0; w < Ways; w++)
          push_rsp(ST_CAND, s, w, 0, tag_vld[row+w] ? tag_addr[row+w] : '0, w == Ways-1);
      end
      FN_REPL: begin
        for (int w = 0; w < Ways; w++)
          if (tag_vld[row+w] && tag_addr[row+w] == a) begin
            for (int v = 0; v < VictimSlots; v++)
              if (!vic_vld[v]) begin
                vic_vld[v] = 1'b1; vic_addr[v] = a; tag_addr[row+w] = na;
                push_rsp(ST_REPL, s, w, v, na, 1'b1); return;
              end
            break;  // victim list full
          end
        push_rsp(ST_ERR, s, 0, 0, '0, 1'b1);
      end
      default: begin
        for (int v = 0; v < VictimSlots; v++)
          if (vic_vld[v] && vic_addr[v] == a) begin
            vic_vld[v] = 1'b0;
            push_rsp(ST_INVAL, s, 0, v, a, 1'b1); return;
          end
        push_rsp(ST_ERR, s, 0, 0, '0, 1'b1);
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) tx_calm <= ~tx_calm;
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!idle_off && !tx_calm && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          func_i <= pending_reqs[0].func;
          address_i <= pending_reqs[0].addr;
          new_address_i <= pending_reqs[0].new_addr;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stall bursts plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_calm <= ~rx_calm;
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 300;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!idle_off && !rx_calm && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: predict on request accept, compare on result accept
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && in_valid_i && in_ready_o)
      predict_directory(func_e'(func_i), address_i, new_address_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result status=%0d set_idx=%0d", status_o, set_idx_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (status_o != e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (set_idx_o != e.set) begin
          $error("set_idx exp %0d got %0d", e.set, set_idx_o); errors++;
        end
        if (way_o != e.way) begin
          $error("way exp %0d got %0d", e.way, way_o); errors++;
        end
        if (victim_slot_o != e.slot) begin
          $error("victim_slot exp %0d got %0d", e.slot, victim_slot_o); errors++;
        end
        if (entry_address_o != e.addr) begin
          $error("entry_address exp %h got %h", e.addr, entry_address_o); errors++;
        end
        if (last_o != e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(cfg_e idx, int val, int width);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    // upper bits are don't-care for the block; toggle them anyway
    cfg_data_i <= (32'(val) & ((32'd1 << width) - 1)) | ($urandom() << width);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LOG_BLOCK: lg_block = val & 4'hF;
      CFG_LOG_MC:    lg_mc = val & 3'h7;
      CFG_LOG_STACK: lg_stack = val & 6'h3F;
      default:       lg_cores = val & 4'hF;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_req(func_e f, addr_t a, addr_t na);
    dir_req_t r;
    r.func = f; r.addr = a; r.new_addr = na;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic addr_t rand_addr();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  // small address pool that lands in two sets, so ways fill and victims recur
  task automatic build_pool();
    set_t  t0, t1, s;
    addr_t a;
    addr_pool.delete();
    t0 = hashed_set(rand_addr());
    t1 = hashed_set(rand_addr());
    while (addr_pool.size() < 24) begin
      a = rand_addr();
      s = hashed_set(a);
      if (s == t0 || s == t1) addr_pool = {addr_pool, a};
    end
  endtask

  task automatic add_random(int n);
    func_e f;
    addr_t a, na;
    int    pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      f = (pick < 40) ? FN_LOOKUP : (pick < 50) ? FN_CAND : (pick < 75) ? FN_REPL : FN_INVAL;
      a = ($urandom_range(0, 9) == 0) ? rand_addr()
                                      : addr_pool[$urandom_range(0, addr_pool.size()-1)];
      na = ($urandom_range(0, 4) == 0) ? rand_addr()
                                       : addr_pool[$urandom_range(0, addr_pool.size()-1)];
      add_req(f, a, na);
    end
  endtask

  initial begin
    int phase_cfg [5][4] = '{'{6, 0, 24, 4}, '{0, 0, 12, 0}, '{12, 6, 40, 10},
                            '{15, 7, 63, 15}, '{7, 2, 30, 6}};
    lg_block = 6; lg_mc = 0; lg_stack = 24; lg_cores = 4;
    for (int i = 0; i < NumSets*Ways; i++) begin
      tag_vld[i] = 1'b0; tag_addr[i] = '0;
    end
    for (int i = 0; i < VictimSlots; i++) begin
      vic_vld[i] = 1'b0; vic_addr[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening at reset settings
    add_req(FN_INVAL, '0, '0);
    add_req(FN_REPL, 48'h123, '1);
    add_req(FN_CAND, '0, '0);
    add_req(FN_LOOKUP, '0, '1);
    add_req(FN_LOOKUP, '0, '0);
    add_req(FN_LOOKUP, '1, '0);
    add_req(FN_CAND, '0, '0);
    add_req(FN_REPL, '0, '1);
    add_req(FN_LOOKUP, '0, '0);
    add_req(FN_LOOKUP, '1, '0);
    add_req(FN_INVAL, '0, '0);
    add_req(FN_INVAL, '0, '0);
    add_req(FN_REPL, '1, '0);
    add_req(FN_CAND, '1, '0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_LOG_BLOCK, phase_cfg[p][0], 4);
      write_reg(CFG_LOG_MC, phase_cfg[p][1], 3);
      write_reg(CFG_LOG_STACK, phase_cfg[p][2], 6);
      write_reg(CFG_LOG_CORES, phase_cfg[p][3], 4);
      build_pool();
      if (p == 4) idle_off = 1'b1;
      add_random(62);
      if (p == 1) hold_req = 1'b1;
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
